/* hdl/cwva_pkg.sv */
// cwva_pkg: shared constants, types and helpers for the cylinder window
// voltage averager. No dependencies.
`timescale 1ns / 1ps

package cwva_pkg;

  localparam int RAW_W  = 16;
  localparam int VOLT_W = 10;
  localparam int CNT_W  = 4;
  localparam int SUM_W  = RAW_W + 1;

  localparam logic [VOLT_W-1:0] VOLT_MAX  = 10'd1023;
  localparam logic [CNT_W-1:0]  CNT_RESET = 4'd4;

  // Window length codes
  localparam logic [CNT_W-1:0] CNT_FIXED  = 4'd0;
  localparam logic [CNT_W-1:0] CNT_SINGLE = 4'd1;
  localparam logic [CNT_W-1:0] CNT_PAIR   = 4'd2;
  localparam logic [CNT_W-1:0] CNT_TRIPLE = 4'd3;
  localparam logic [CNT_W-1:0] CNT_QUAD   = 4'd4;

  // Sample kind codes
  localparam logic KIND_RUN   = 1'b0;
  localparam logic KIND_STALL = 1'b1;

  // Divide by three: (x * DIV3_MULT) >> DIV3_SHIFT, exact for x < 2**17
  localparam int               DIV3_SHIFT = 18;
  localparam logic [SUM_W-1:0] DIV3_MULT  = 17'd87382;

  typedef struct packed {
    logic [VOLT_W-1:0] one_back;
    logic [VOLT_W-1:0] two_back;
    logic [VOLT_W-1:0] three_back;
  } hist_t;

  function automatic logic [VOLT_W-1:0] sat_volt(input logic [SUM_W-1:0] v);
    logic [SUM_W-1:0] lim;
    lim = {{(SUM_W-VOLT_W){1'b0}}, VOLT_MAX};
    sat_volt = (v > lim) ? VOLT_MAX : v[VOLT_W-1:0];
  endfunction

endpackage

/* hdl/cwva_history.sv */
// cwva_history: three-deep history of clamped samples, newest first.
// Depends on cwva_pkg.
`timescale 1ns / 1ps

module cwva_history (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         shift_en,
  input  logic [cwva_pkg::VOLT_W-1:0]  sample,
  output cwva_pkg::hist_t              hist
);
  import cwva_pkg::*;

  hist_t hist_r;
  hist_t hist_nxt;

  always_comb begin
    hist_nxt = hist_r;
    if (shift_en) begin
      hist_nxt.three_back = hist_r.two_back;
      hist_nxt.two_back   = hist_r.one_back;
      hist_nxt.one_back   = sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
    end else begin
      hist_r <= hist_nxt;
    end
  end

  assign hist = hist_r;

  a_shift_newest: assert property (@(posedge clk) disable iff (!rst_n)
    shift_en |=> hist_r.one_back == $past(sample)
                 && hist_r.three_back == $past(hist_r.two_back))
    else $error("history did not shift in the new sample");

  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !shift_en |=> $stable(hist_r))
    else $error("history changed without a running transfer");

endmodule

/* hdl/cwva_filter.sv */
// cwva_filter: window average over the current sample and the history,
// selected by the window length; stalled samples are only clamped. Depends on cwva_pkg.
`timescale 1ns / 1ps

module cwva_filter (
  input  logic                         kind,
  input  logic [cwva_pkg::RAW_W-1:0]   raw_voltage,
  input  logic [cwva_pkg::CNT_W-1:0]   cylinder_count,
  input  cwva_pkg::hist_t              hist,
  output logic [cwva_pkg::VOLT_W-1:0]  filtered_voltage,
  output logic                         config_error,
  output logic [cwva_pkg::VOLT_W-1:0]  clamped_sample
);
  import cwva_pkg::*;

  logic [SUM_W-1:0]   raw_ext;
  logic [SUM_W-1:0]   one_ext;
  logic [SUM_W-1:0]   two_ext;
  logic [SUM_W-1:0]   three_ext;
  logic [SUM_W-1:0]   sum_pair;
  logic [SUM_W-1:0]   sum_triple;
  logic [SUM_W-1:0]   sum_quad;
  logic [2*SUM_W-1:0] prod3;
  logic [SUM_W-1:0]   quot3;
  logic [SUM_W-1:0]   acc;
  logic               err;

  assign raw_ext   = {1'b0, raw_voltage};
  assign one_ext   = {{(SUM_W-VOLT_W){1'b0}}, hist.one_back};
  assign two_ext   = {{(SUM_W-VOLT_W){1'b0}}, hist.two_back};
  assign three_ext = {{(SUM_W-VOLT_W){1'b0}}, hist.three_back};

  assign sum_pair   = raw_ext + one_ext + SUM_W'(1);
  assign sum_triple = raw_ext + one_ext + two_ext;
  assign sum_quad   = raw_ext + one_ext + two_ext + three_ext + SUM_W'(2);

  // Divide by three through the reciprocal
  assign prod3 = {{SUM_W{1'b0}}, sum_triple} * {{SUM_W{1'b0}}, DIV3_MULT};
  assign quot3 = {1'b0, prod3[2*SUM_W-1:DIV3_SHIFT]};

  always_comb begin
    err = 1'b0;
    unique case (cylinder_count)
      CNT_FIXED:  acc = {{(SUM_W-VOLT_W){1'b0}}, VOLT_MAX};
      CNT_SINGLE: acc = raw_ext;
      CNT_PAIR:   acc = sum_pair >> 1;
      CNT_TRIPLE: acc = quot3;
      CNT_QUAD:   acc = sum_quad >> 2;
      default: begin
        acc = '0;
        err = 1'b1;
      end
    endcase
  end

  assign clamped_sample = sat_volt(raw_ext);

  always_comb begin
    if (kind == KIND_STALL) begin
      filtered_voltage = clamped_sample;
      config_error     = 1'b0;
    end else begin
      filtered_voltage = sat_volt(acc);
      config_error     = err;
    end
  end

endmodule

/* hdl/cylinder_window_voltage_averager.sv */
// cylinder_window_voltage_averager: top level with input and result registers.
// Depends on cwva_pkg, cwva_history and cwva_filter.
`timescale 1ns / 1ps

// Takes one sensor sample per cycle while in_stall is low and returns one
// filtered result per sample via the input register, then the result register.
// Running samples are averaged over the last cylinder_count samples (1 to 4;
// 0 gives full scale, above 4 gives 0 with config_error set) and shift the
// history as they pass the arithmetic stage; stalled samples are only clamped
// and leave the history alone. A new sample is taken while a result waits,
// as long as the input register is free. Write cylinder_count only when idle.
module cylinder_window_voltage_averager (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [cwva_pkg::CNT_W-1:0]   cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_kind,
  input  logic [cwva_pkg::RAW_W-1:0]   in_raw_voltage,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [cwva_pkg::VOLT_W-1:0]  out_filtered_voltage,
  output logic                         out_config_error
);
  import cwva_pkg::*;

  logic [CNT_W-1:0]  cnt_r;
  logic              s0_valid_r;
  logic              s0_kind_r;
  logic [RAW_W-1:0]  s0_raw_r;
  logic              out_valid_r;
  logic [VOLT_W-1:0] out_volt_r;
  logic              out_err_r;

  logic              advance;
  logic              load_s0;
  logic              shift_en;
  hist_t             hist;
  logic [VOLT_W-1:0] filt_volt;
  logic              filt_err;
  logic [VOLT_W-1:0] clamped;

  // Move the result stage when it is empty or its transfer completes
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s0_valid_r && !advance;
  assign load_s0  = in_valid && !in_stall;
  assign shift_en = s0_valid_r && advance && (s0_kind_r == KIND_RUN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= CNT_RESET;
    end else if (cfg_wr_en) begin
      cnt_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_s0) begin
        s0_valid_r <= 1'b1;
      end else if (advance) begin
        s0_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= s0_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_s0) begin
      s0_kind_r <= in_kind;
      s0_raw_r  <= in_raw_voltage;
    end
    if (advance && s0_valid_r) begin
      out_volt_r <= filt_volt;
      out_err_r  <= filt_err;
    end
  end

  cwva_filter u_filter (
    .kind             (s0_kind_r),
    .raw_voltage      (s0_raw_r),
    .cylinder_count   (cnt_r),
    .hist             (hist),
    .filtered_voltage (filt_volt),
    .config_error     (filt_err),
    .clamped_sample   (clamped)
  );

  cwva_history u_history (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (shift_en),
    .sample   (clamped),
    .hist     (hist)
  );

  assign out_valid            = out_valid_r;
  assign out_filtered_voltage = out_volt_r;
  assign out_config_error     = out_err_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> out_volt_r == '0)
    else $error("config error result carries a nonzero voltage");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_valid_r && advance) |=> out_valid_r)
    else $error("item lost between input and result registers");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s0_valid_r && out_valid_r && out_stall))
    else $error("input stalled with room in the pipeline");

endmodule

/* sim/cylinder_window_voltage_averager_tb.sv */
// Self-checking testbench for cylinder_window_voltage_averager: windowed and clamped
// sensor samples are predicted in a scoreboard class and compared with every result.
// Depends on cwva_pkg and the averager RTL.
`timescale 1ns / 1ps

class filtered_voltage_ledger;
  logic [cwva_pkg::CNT_W-1:0]  window_len;
  logic [cwva_pkg::VOLT_W-1:0] one_back;
  logic [cwva_pkg::VOLT_W-1:0] two_back;
  logic [cwva_pkg::VOLT_W-1:0] three_back;
  logic [cwva_pkg::VOLT_W-1:0] want_volt[$];
  logic                        want_err[$];
  int mismatches;
  int running_seen;
  int stalled_seen;
  int error_results;
  int results_checked;

  function new();
    window_len = cwva_pkg::CNT_RESET;
    one_back   = '0;
    two_back   = '0;
    three_back = '0;
    mismatches = 0;
    running_seen = 0;
    stalled_seen = 0;
    error_results = 0;
    results_checked = 0;
  endfunction

  function logic [cwva_pkg::VOLT_W-1:0] full_scale_limit(input logic [17:0] v);
    return (v > 18'(cwva_pkg::VOLT_MAX)) ? cwva_pkg::VOLT_MAX : v[cwva_pkg::VOLT_W-1:0];
  endfunction

  function int pending();
    return want_volt.size();
  endfunction

  // Work out the result of one accepted sample and advance the history.
  function void note_sample(input logic kind, input logic [cwva_pkg::RAW_W-1:0] raw);
    logic [17:0] total;
    logic        err;
    err = 1'b0;
    if (kind == cwva_pkg::KIND_STALL) begin
      stalled_seen++;
      want_volt.push_back(full_scale_limit(18'(raw)));
      want_err.push_back(1'b0);
      return;
    end
    running_seen++;
    case (window_len)
      cwva_pkg::CNT_FIXED:  total = 18'(cwva_pkg::VOLT_MAX);
      cwva_pkg::CNT_SINGLE: total = 18'(raw);
      cwva_pkg::CNT_PAIR:   total = (18'(raw) + 18'(one_back) + 18'd1) / 18'd2;
      cwva_pkg::CNT_TRIPLE: total = (18'(raw) + 18'(one_back) + 18'(two_back)) / 18'd3;
      cwva_pkg::CNT_QUAD: begin
        total = (18'(raw) + 18'(one_back) + 18'(two_back) + 18'(three_back) + 18'd2)
                / 18'd4;
      end
      default: begin
        total = '0;
        err   = 1'b1;
      end
    endcase
    want_volt.push_back(full_scale_limit(total));
    want_err.push_back(err);
    three_back = two_back;
    two_back   = one_back;
    one_back   = full_scale_limit(18'(raw));
  endfunction

  task report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  task check_result(input logic [cwva_pkg::VOLT_W-1:0] volt, input logic err);
    logic [cwva_pkg::VOLT_W-1:0] exp_volt;
    logic                        exp_err;
    if (want_volt.size() == 0) begin
      report_mismatch($sformatf("unexpected result volt=%0d err=%0d", volt, err));
      return;
    end
    exp_volt = want_volt.pop_front();
    exp_err  = want_err.pop_front();
    results_checked++;
    if (err) error_results++;
    if (volt !== exp_volt)
      report_mismatch($sformatf("filtered_voltage %0d, expected %0d", volt, exp_volt));
    if (err !== exp_err)
      report_mismatch($sformatf("config_error %0b, expected %0b", err, exp_err));
  endtask
endclass

module cylinder_window_voltage_averager_tb;
  import cwva_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int LONG_HOLD     = 64;
  localparam int PHASE_COUNT   = 12;
  localparam int PHASE_SAMPLES = 154;

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [CNT_W-1:0]   cfg_wr_data;
  logic               in_valid;
  logic               in_stall;
  logic               in_kind;
  logic [RAW_W-1:0]   in_raw_voltage;
  logic               out_valid;
  logic               out_stall;
  logic [VOLT_W-1:0]  out_filtered_voltage;
  logic               out_config_error;

  filtered_voltage_ledger ledger;
  bit calm;
  bit hold_off_req;
  int cycle_count;
  int settings_used;

  cylinder_window_voltage_averager u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_kind              (in_kind),
    .in_raw_voltage       (in_raw_voltage),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_filtered_voltage (out_filtered_voltage),
    .out_config_error     (out_config_error)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("Verification failed");
    $finish;
  end

  // Check the departing result before noting the arriving sample.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) ledger.check_result(out_filtered_voltage, out_config_error);
      if (in_valid && !in_stall) ledger.note_sample(in_kind, in_raw_voltage);
    end
  end

  // Result side: random stall bursts, plus one long hold on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat (calm ? 1 : $urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  task send_sample(input logic kind, input logic [RAW_W-1:0] raw);
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_raw_voltage <= raw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Hold the input until every expected result is back, then let the pipe empty.
  // Wait for a clock edge first so the last transfer in has been noted by the monitor.
  task drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (ledger.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task set_window_length(input logic [CNT_W-1:0] len);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    ledger.window_len = len;
    settings_used++;
  endtask

  function logic [RAW_W-1:0] pick_raw();
    case ($urandom_range(0, 9))
      0, 1: return RAW_W'($urandom_range(0, 65535));
      2: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return '1;
          2: return RAW_W'(VOLT_MAX);
          default: return RAW_W'(VOLT_MAX) + 1'b1;
        endcase
      end
      default: return RAW_W'($urandom_range(0, 1023));
    endcase
  endfunction

  // Mostly real window lengths, sometimes any code at all.
  function logic [CNT_W-1:0] pick_window(input int phase);
    case (phase)
      0: return CNT_QUAD;
      1: return CNT_TRIPLE;
      2: return CNT_PAIR;
      3: return CNT_SINGLE;
      4: return CNT_FIXED;
      5: return 4'd15;
      default: begin
        if (PHASE_COUNT - 1 == phase) return CNT_QUAD;
        if ($urandom_range(0, 3) != 0) return CNT_W'($urandom_range(1, 4));
        return CNT_W'($urandom_range(0, 15));
      end
    endcase
  endfunction

  initial begin
    ledger         = new();
    calm           = 1'b0;
    hold_off_req   = 1'b0;
    settings_used  = 0;
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_valid       = 1'b0;
    in_kind        = KIND_RUN;
    in_raw_voltage = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset window of four: saturating sum, then stalled samples leave history alone.
    send_sample(KIND_RUN, 16'hFFFF);
    send_sample(KIND_RUN, 16'hFFFF);
    send_sample(KIND_RUN, 16'hFFFF);
    send_sample(KIND_RUN, 16'hFFFF);
    send_sample(KIND_STALL, 16'hFFFF);
    send_sample(KIND_STALL, 16'd1023);
    send_sample(KIND_RUN, 16'd0);
    set_window_length(CNT_FIXED);
    send_sample(KIND_RUN, 16'd100);
    send_sample(KIND_STALL, 16'd2000);
    set_window_length(CNT_SINGLE);
    send_sample(KIND_RUN, 16'd1024);
    send_sample(KIND_RUN, 16'd1023);
    set_window_length(CNT_PAIR);
    send_sample(KIND_RUN, 16'd0);
    send_sample(KIND_RUN, 16'd1);
    set_window_length(CNT_TRIPLE);
    send_sample(KIND_RUN, 16'd2);
    send_sample(KIND_RUN, 16'd0);
    set_window_length(4'd15);
    send_sample(KIND_RUN, 16'd500);
    send_sample(KIND_STALL, 16'd700);
    set_window_length(4'd5);
    send_sample(KIND_RUN, 16'hFFFF);

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      set_window_length(pick_window(phase));
      calm = (phase == PHASE_COUNT - 1);
      for (int n = 0; n < PHASE_SAMPLES; n++) begin
        // Back up the pipe once so the block has to stall its input.
        if (phase == 2 && n == 30) hold_off_req = 1'b1;
        send_sample(($urandom_range(0, 5) == 0) ? KIND_STALL : KIND_RUN, pick_raw());
      end
    end
    drain_results();
    repeat (8) @(posedge clk);

    $display("Run covered %0d running and %0d stalled samples over %0d window settings,",
             ledger.running_seen, ledger.stalled_seen, settings_used);
    $display("with %0d results checked, %0d of them flagged as configuration errors.",
             ledger.results_checked, ledger.error_results);
    if (ledger.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/cwva_pkg.sv
hdl/cwva_history.sv
hdl/cwva_filter.sv
hdl/cylinder_window_voltage_averager.sv
sim/cylinder_window_voltage_averager_tb.sv
